FILE: hw/rtl/ubd_pkg.sv
// Shared widths, reset values and register codes for the baud divisor rescaler.
`timescale 1ns / 1ps

package ubd_pkg;

	localparam int BAUD_W  = 24;
	localparam int CAP_W   = 22;
	localparam int REF_W   = 24;
	localparam int CLK_W   = 32;
	localparam int INT_W   = 16;
	localparam int FRAC_W  = 6;
	localparam int WDATA_W = 32;
	localparam int IDX_W   = 2;

	// x16 oversampling on the clock path
	localparam int OVS_SHIFT   = 4;
	// six fraction bits plus one rounding bit
	localparam int ROUND_SHIFT = FRAC_W + 1;

	// dividend: cap * ref + baud/2 needs CAP_W + REF_W + 1 bits
	localparam int DIVIDEND_W = CAP_W + REF_W + 1;
	localparam int DIVISOR_W  = BAUD_W + OVS_SHIFT;
	// enough quotient bits to see a 16-bit integer plus 7 fraction bits
	localparam int QUO_W      = INT_W + ROUND_SHIFT;

	localparam logic [CAP_W-1:0] CAP_RESET = '0;
	localparam logic [REF_W-1:0] REF_RESET = REF_W'(115200);
	localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(24000000);

	typedef enum logic [IDX_W-1:0] {
		REG_CAPTURED = 2'd0,
		REG_REF_BAUD = 2'd1,
		REG_CLOCK_HZ = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic             done;
		logic             ovf;
		logic [QUO_W-1:0] quo;
	} div_stat_t;

endpackage

FILE: hw/rtl/ubd_if.sv
// Valid/ready channel interfaces for baud requests and divisor results.
`timescale 1ns / 1ps

interface ubd_req_if import ubd_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [BAUD_W-1:0] baud_rate;

	modport source (output valid, output baud_rate, input ready);
	modport sink   (input valid, input baud_rate, output ready);
endinterface

interface ubd_rsp_if import ubd_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [INT_W-1:0]  int_divisor;
	logic [FRAC_W-1:0] frac_divisor;
	logic              accepted;
	logic              used_scaling;

	modport source (output valid, output int_divisor, output frac_divisor,
		output accepted, output used_scaling, input ready);
	modport sink   (input valid, input int_divisor, input frac_divisor,
		input accepted, input used_scaling, output ready);
endinterface

FILE: hw/rtl/ubd_serdiv.sv
// Bit-serial restoring divider, one quotient bit per cycle, sticky overflow.
`timescale 1ns / 1ps

module ubd_serdiv import ubd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output div_stat_t             stat
);

	localparam int CNT_W = $clog2(DIVIDEND_W);

	logic [DIVIDEND_W-1:0] num_q;
	logic [DIVISOR_W-1:0]  den_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [QUO_W-1:0]      quo_q;
	logic                  ovf_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W+1:0]  diff;
	logic                  ge;

	// shift in the next dividend bit, subtract if it fits
	assign trial = {rem_q, num_q[DIVIDEND_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, den_q};
	assign ge    = ~diff[DIVISOR_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			ovf_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				num_q  <= dividend;
				den_q  <= divisor;
				rem_q  <= '0;
				quo_q  <= '0;
				ovf_q  <= 1'b0;
				cnt_q  <= CNT_W'(DIVIDEND_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				num_q <= {num_q[DIVIDEND_W-2:0], 1'b0};
				rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
				ovf_q <= ovf_q | quo_q[QUO_W-1];
				quo_q <= {quo_q[QUO_W-2:0], ge};
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	assign stat = '{done: done_q, ovf: ovf_q, quo: quo_q};

endmodule

FILE: hw/rtl/uart_baud_divisor_rescale.sv
// Top level: UART integer/fractional baud divisor computation and hold.
`timescale 1ns / 1ps
// Paths: the clock path goes straight to the divider; the scaling path first runs a
//   shift-add multiply, then the divide; a zero baud is staged without either.
// Flow: one request at a time; the next beat is taken the cycle after the result is
//   staged, later while an earlier result waits for ready.
// Cost is set by the bit-serial divider: one quotient bit per cycle over a 47-bit dividend.
// Reset (arst_n low, async): held divisors zero, config regs to their defaults, no result.

module uart_baud_divisor_rescale import ubd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_index,
	input  logic [WDATA_W-1:0] wr_data,
	ubd_req_if.sink            req,
	ubd_rsp_if.source          rsp
);

	localparam int MCNT_W = $clog2(CAP_W);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_PUT
	} state_t;

	// configuration registers
	logic [CAP_W-1:0] cap_q;
	logic [REF_W-1:0] ref_q;
	logic [CLK_W-1:0] clk_hz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CAP_RESET;
			ref_q    <= REF_RESET;
			clk_hz_q <= CLK_RESET;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_CAPTURED: cap_q    <= wr_data[CAP_W-1:0];
				REG_REF_BAUD: ref_q    <= wr_data[REF_W-1:0];
				REG_CLOCK_HZ: clk_hz_q <= wr_data[CLK_W-1:0];
				default: ;
			endcase
		end
	end

	state_t                state_q;
	logic [CAP_W-1:0]      mplr_q;    // captured divisor, consumed LSB first
	logic [DIVIDEND_W-1:0] mcand_q;   // reference baud, shifted left each step
	logic [DIVIDEND_W-1:0] acc_q;     // product accumulator, then dividend
	logic [DIVISOR_W-1:0]  den_q;
	logic [MCNT_W-1:0]     mcnt_q;
	logic                  start_q;
	logic                  scal_q;
	logic                  ok_q;
	logic [INT_W-1:0]      cand_int_q;
	logic [FRAC_W-1:0]     cand_frac_q;
	logic [INT_W-1:0]      held_int_q;
	logic [FRAC_W-1:0]     held_frac_q;
	logic                  out_valid_q;
	logic [INT_W-1:0]      out_int_q;
	logic [FRAC_W-1:0]     out_frac_q;
	logic                  out_ok_q;
	logic                  out_scal_q;

	div_stat_t             dstat;

	logic                  take;
	logic                  out_free;
	logic [BAUD_W-1:0]     baud;

	// result decode
	logic                  sc_bad;
	logic                  ck_bad;
	logic [INT_W-1:0]      ck_int;
	logic [ROUND_SHIFT:0]  ck_frac_rnd;

	assign baud     = req.baud_rate;
	assign take     = req.valid && (state_q == S_IDLE);
	assign out_free = !out_valid_q || rsp.ready;

	// scaling: quotient is int*64 + frac, must fit 22 bits with nonzero integer
	assign sc_bad = dstat.ovf || dstat.quo[QUO_W-1] ||
		(dstat.quo[QUO_W-2:FRAC_W] == '0);
	// clock path: quotient carries 7 fraction bits; round on the last one
	assign ck_int      = dstat.quo[QUO_W-1:ROUND_SHIFT];
	assign ck_bad      = dstat.ovf || (ck_int == '0);
	assign ck_frac_rnd = {1'b0, dstat.quo[ROUND_SHIFT-1:0]} + 1'b1;

	ubd_serdiv u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (acc_q),
		.divisor  (den_q),
		.stat     (dstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mplr_q      <= '0;
			mcand_q     <= '0;
			acc_q       <= '0;
			den_q       <= '0;
			mcnt_q      <= '0;
			start_q     <= 1'b0;
			scal_q      <= 1'b0;
			ok_q        <= 1'b0;
			cand_int_q  <= '0;
			cand_frac_q <= '0;
			held_int_q  <= '0;
			held_frac_q <= '0;
			out_valid_q <= 1'b0;
			out_int_q   <= '0;
			out_frac_q  <= '0;
			out_ok_q    <= 1'b0;
			out_scal_q  <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (out_valid_q && rsp.ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						priority if (baud == '0) begin
							// no divide at all: reject, keep held values
							ok_q    <= 1'b0;
							scal_q  <= 1'b0;
							state_q <= S_PUT;
						end else if (cap_q != '0) begin
							scal_q  <= 1'b1;
							mplr_q  <= cap_q;
							mcand_q <= DIVIDEND_W'(ref_q);
							acc_q   <= DIVIDEND_W'(baud >> 1);
							den_q   <= DIVISOR_W'(baud);
							mcnt_q  <= MCNT_W'(CAP_W - 1);
							state_q <= S_MUL;
						end else begin
							scal_q  <= 1'b0;
							acc_q   <= DIVIDEND_W'({clk_hz_q, {ROUND_SHIFT{1'b0}}});
							den_q   <= {baud, {OVS_SHIFT{1'b0}}};
							start_q <= 1'b1;
							state_q <= S_DIV;
						end
					end
				end
				S_MUL: begin
					if (mplr_q[0])
						acc_q <= acc_q + mcand_q;
					mplr_q  <= mplr_q >> 1;
					mcand_q <= {mcand_q[DIVIDEND_W-2:0], 1'b0};
					if (mcnt_q == '0) begin
						start_q <= 1'b1;
						state_q <= S_DIV;
					end else begin
						mcnt_q <= mcnt_q - 1'b1;
					end
				end
				S_DIV: begin
					if (dstat.done) begin
						if (scal_q) begin
							ok_q        <= !sc_bad;
							cand_int_q  <= dstat.quo[QUO_W-2:FRAC_W];
							cand_frac_q <= dstat.quo[FRAC_W-1:0];
						end else begin
							ok_q        <= !ck_bad;
							cand_int_q  <= ck_int;
							// a fraction rounding up to 64 wraps to 0, no carry
							cand_frac_q <= ck_frac_rnd[FRAC_W:1];
						end
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (out_free) begin
						if (ok_q) begin
							held_int_q  <= cand_int_q;
							held_frac_q <= cand_frac_q;
						end
						out_int_q   <= ok_q ? cand_int_q : held_int_q;
						out_frac_q  <= ok_q ? cand_frac_q : held_frac_q;
						out_ok_q    <= ok_q;
						out_scal_q  <= scal_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = out_valid_q;
	assign rsp.int_divisor  = out_int_q;
	assign rsp.frac_divisor = out_frac_q;
	assign rsp.accepted     = out_ok_q;
	assign rsp.used_scaling = out_scal_q;

`ifndef SYNTH
	// a waiting result always mirrors the divisors now held
	a_out_matches_held: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.int_divisor == held_int_q && rsp.frac_divisor == held_frac_q))
		else $error("result beat disagrees with held divisors");

	// an accepted divisor never has a zero integer part
	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.accepted) |-> (rsp.int_divisor != '0))
		else $error("accepted divisor with zero integer part");

	// a new result only comes from the staging state
	a_rose_from_put: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_PUT))
		else $error("result beat raised outside staging");

	// divider finishes only while the sequencer waits for it
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		dstat.done |-> (state_q == S_DIV))
		else $error("divider done outside divide state");
`endif

endmodule

FILE: tb/tb_top.sv
// Self-checking bench for the UART baud divisor rescaler: directed corners, then random requests.
`timescale 1ns / 1ps

module tb_top;
	import ubd_pkg::*;

	// Unmapped register slot; writes to it must leave the divisors untouched
	localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic [IDX_W-1:0] REG_ORDER [4] = '{REG_CAPTURED, REG_REF_BAUD, REG_CLOCK_HZ,
		REG_SPARE};

	// Write-select bits for apply_config, one per entry of REG_ORDER
	localparam logic [3:0] W_CAP   = 4'b0001;
	localparam logic [3:0] W_REF   = 4'b0010;
	localparam logic [3:0] W_CLK   = 4'b0100;
	localparam logic [3:0] W_SPARE = 4'b1000;

	localparam logic [63:0] BAUD_MAX   = (64'd1 << BAUD_W) - 1;
	localparam logic [63:0] INT_MAX    = (64'd1 << INT_W) - 1;
	localparam logic [63:0] FRAC_ONE   = 64'd1 << FRAC_W;
	localparam logic [63:0] OVERSAMPLE = 64'd1 << OVS_SHIFT;
	// scaled divisor (int * 64 + frac) must stay below this to be accepted
	localparam logic [63:0] SCALED_LIMIT = (INT_MAX + 1) * FRAC_ONE;
	localparam logic [WDATA_W-1:0] CAP_MAX = (32'd1 << CAP_W) - 1;

	localparam int unsigned STD_BAUDS [8] = '{9600, 19200, 38400, 57600, 115200, 230400,
		460800, 921600};
	localparam int unsigned STD_CLOCKS [6] = '{1843200, 3686400, 14745600, 24000000,
		48000000, 100000000};

	localparam int ITEMS_PER_PHASE  = 70;
	localparam int PHASES_PER_MODE  = 6;
	localparam int SETTLE_CYCLES    = 100;

	typedef struct packed {
		logic [INT_W-1:0]  int_divisor;
		logic [FRAC_W-1:0] frac_divisor;
		logic              accepted;
		logic              used_scaling;
	} divisor_result_t;

	logic               clk;
	logic               arst_n;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_index;
	logic [WDATA_W-1:0] wr_data;

	ubd_req_if req_ch ();
	ubd_rsp_if rsp_ch ();

	uart_baud_divisor_rescale i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	// Shadow copies of the config registers and of the held divisors
	logic [CAP_W-1:0]  captured_model;
	logic [REF_W-1:0]  ref_baud_model;
	logic [CLK_W-1:0]  clock_hz_model;
	logic [INT_W-1:0]  held_int_model;
	logic [FRAC_W-1:0] held_frac_model;

	logic [BAUD_W-1:0] pending_bauds [$];
	divisor_result_t   expected_divisors [$];

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int          mismatch_count;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Divisor computation at 64 bits so nothing wraps. Updates the held divisors when
	// the new pair is in range; a zero baud is always rejected and reported as not scaled.
	function automatic divisor_result_t compute_divisors(input logic [BAUD_W-1:0] baud);
		divisor_result_t res;
		logic [63:0]     b;
		logic [63:0]     scaled;
		logic [63:0]     d;
		logic [63:0]     rem;
		logic [63:0]     idiv;
		logic [63:0]     fdiv;
		logic            ok;
		logic            scaling;
		b       = 64'(baud);
		idiv    = '0;
		fdiv    = '0;
		ok      = 1'b0;
		scaling = 1'b0;
		if (captured_model != '0 && b != '0) begin
			scaled  = (64'(captured_model) * 64'(ref_baud_model) + b / 2) / b;
			idiv    = scaled / FRAC_ONE;
			fdiv    = scaled % FRAC_ONE;
			scaling = 1'b1;
			ok      = 1'b1;
		end else if (b != '0) begin
			d    = OVERSAMPLE * b;
			rem  = 64'(clock_hz_model) % d;
			idiv = 64'(clock_hz_model) / d;
			// rounding up to a full 64 wraps to zero, no carry into the integer part
			fdiv = (rem * FRAC_ONE + d / 2) / d;
			ok   = 1'b1;
		end
		if (ok && (idiv < 1 || idiv > INT_MAX))
			ok = 1'b0;
		if (ok) begin
			held_int_model  = idiv[INT_W-1:0];
			held_frac_model = fdiv[FRAC_W-1:0];
		end
		res.int_divisor  = held_int_model;
		res.frac_divisor = held_frac_model;
		res.accepted     = ok;
		res.used_scaling = scaling;
		return res;
	endfunction

	function automatic logic [31:0] random_bits(input int unsigned w);
		if (w >= 32)
			return $urandom();
		return $urandom() & ((32'd1 << w) - 1);
	endfunction

	// Mostly requests whose divisor lands in range for the current setup, the rest
	// range edges, zero, all-ones and arbitrary widths.
	function automatic logic [BAUD_W-1:0] pick_baud();
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] v;
		int unsigned sel;
		sel = $urandom_range(99);
		if (captured_model != '0) begin
			hi = 64'(captured_model) * 64'(ref_baud_model) / FRAC_ONE;
			lo = 64'(captured_model) * 64'(ref_baud_model) / SCALED_LIMIT + 1;
		end else begin
			hi = 64'(clock_hz_model) / OVERSAMPLE;
			lo = 64'(clock_hz_model) / (OVERSAMPLE * (INT_MAX + 1)) + 1;
		end
		if (hi > BAUD_MAX)
			hi = BAUD_MAX;
		if (sel < 5)
			return '0;
		if (sel < 10)
			return '1;
		if (sel < 22 || lo > hi)
			return BAUD_W'(random_bits($urandom_range(BAUD_W, 1)));
		if (sel < 34) begin
			case ($urandom_range(3))
				0:       v = lo - 1;
				1:       v = lo;
				2:       v = hi;
				default: v = hi + 1;
			endcase
			return BAUD_W'(v);
		end
		if (sel < 67)
			return BAUD_W'($urandom_range(32'(hi), 32'(lo)));
		// log-spread inside the range so small bauds show up too
		v = 64'(random_bits($urandom_range(BAUD_W, 1)));
		if (v < lo)
			v = lo;
		if (v > hi)
			v = hi;
		return BAUD_W'(v);
	endfunction

	function automatic void check_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			mismatch_count++;
		end
	endfunction

	// Request driver: fed from pending_bauds, predicts on every accepted beat
	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				expected_divisors.push_back(compute_divisors(req_ch.baud_rate));
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_bauds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_ch.valid     <= 1'b1;
					req_ch.baud_rate <= pending_bauds.pop_front();
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random backpressure
	always @(posedge clk) begin : rsp_monitor
		divisor_result_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_divisors.size() == 0) begin
					$error("result beat with nothing outstanding: int_divisor %0d",
						rsp_ch.int_divisor);
					mismatch_count++;
				end else begin
					want = expected_divisors.pop_front();
					check_field("int_divisor", 32'(want.int_divisor), 32'(rsp_ch.int_divisor));
					check_field("frac_divisor", 32'(want.frac_divisor),
						32'(rsp_ch.frac_divisor));
					check_field("accepted", 32'(want.accepted), 32'(rsp_ch.accepted));
					check_field("used_scaling", 32'(want.used_scaling),
						32'(rsp_ch.used_scaling));
				end
			end
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Block until every queued request went out and every result came back.
	// Sampled on the falling edge so the driver's updates have settled.
	task automatic drain();
		do
			@(negedge clk);
		while (pending_bauds.size() != 0 || req_ch.valid || expected_divisors.size() != 0);
	endtask

	// Write the selected registers back to back, one per cycle; only called while idle
	task automatic apply_config(input logic [3:0] which, input logic [WDATA_W-1:0] cap_val,
		input logic [WDATA_W-1:0] ref_val, input logic [WDATA_W-1:0] clk_val,
		input logic [WDATA_W-1:0] spare_val);
		logic [WDATA_W-1:0] vals [4];
		vals[0] = cap_val;
		vals[1] = ref_val;
		vals[2] = clk_val;
		vals[3] = spare_val;
		for (int i = 0; i < 4; i++) begin
			if (which[i]) begin
				@(posedge clk);
				wr_en    <= 1'b1;
				wr_index <= REG_ORDER[i];
				wr_data  <= vals[i];
				case (REG_ORDER[i])
					REG_CAPTURED: captured_model = vals[i][CAP_W-1:0];
					REG_REF_BAUD: ref_baud_model = vals[i][REF_W-1:0];
					REG_CLOCK_HZ: clock_hz_model = vals[i][CLK_W-1:0];
					default: ;
				endcase
			end
		end
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// Random setup: about 40% clock path, the rest scaling with realistic or wild values.
	// Upper bits beyond each register's width are junk on purpose.
	task automatic choose_config(input bit all_regs);
		logic [3:0]         which;
		logic [WDATA_W-1:0] cap_val;
		logic [WDATA_W-1:0] ref_val;
		logic [WDATA_W-1:0] clk_val;
		which = all_regs ? (W_CAP | W_REF | W_CLK) : 4'($urandom_range(7, 1));
		if ($urandom_range(3) == 0)
			which = which | W_SPARE;
		case ($urandom_range(9))
			0, 1, 2, 3: cap_val = '0;
			4, 5, 6:    cap_val = ($urandom_range(400, 1) << FRAC_W) | $urandom_range(63);
			7:          cap_val = $urandom();
			8:          cap_val = $urandom_range(1) ? CAP_MAX : 32'd1;
			default:    cap_val = random_bits($urandom_range(CAP_W, 1));
		endcase
		case ($urandom_range(5))
			0, 1, 2: ref_val = STD_BAUDS[$urandom_range(7)];
			3:       ref_val = $urandom();
			4:       ref_val = $urandom_range(1) ? 32'((64'd1 << REF_W) - 1) : 32'd1;
			default: ref_val = random_bits($urandom_range(REF_W, 1)) | 32'd1;
		endcase
		case ($urandom_range(5))
			0, 1, 2: clk_val = STD_CLOCKS[$urandom_range(5)];
			3:       clk_val = $urandom() | 32'd1;
			4:       clk_val = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd1;
			default: clk_val = random_bits($urandom_range(CLK_W, 1)) | 32'd1;
		endcase
		apply_config(which, cap_val, ref_val, clk_val, $urandom());
	endtask

	initial begin : stimulus
		arst_n           = 1'b0;
		wr_en            = 1'b0;
		wr_index         = REG_CAPTURED;
		wr_data          = '0;
		req_ch.valid     = 1'b0;
		req_ch.baud_rate = '0;
		rsp_ch.ready     = 1'b0;
		captured_model   = CAP_RESET;
		ref_baud_model   = REF_RESET;
		clock_hz_model   = CLK_RESET;
		held_int_model   = '0;
		held_frac_model  = '0;
		mismatch_count   = 0;
		send_idle_pct    = 14;
		recv_idle_pct    = 57;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset setup, clock path at 24 MHz: zero baud, divisor too big, the last
		// baud still in range, standard rates, divisor of exactly one, divisor of zero
		pending_bauds = '{24'd0, 24'd1, 24'd22, 24'd23, 24'd9600, 24'd115200, 24'd1500000,
			24'd1600000, 24'hFF_FFFF};
		drain();

		// Largest captured divisor (junk above bit 21): zero baud is rejected without scaling;
		// matching the reference gives the top pair 65535 / 63
		apply_config(W_CAP, 32'hFFFF_FFFF, '0, '0, '0);
		pending_bauds = '{24'd0, 24'd1, 24'd115200, 24'd230400, 24'hFF_FFFF};
		drain();

		// Smallest captured divisor with top reference and clock: scaled result
		// below one integer step, far above range, and in range
		apply_config(W_CAP | W_REF | W_CLK, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
		pending_bauds = '{24'hFF_FFFF, 24'd1, 24'd512};
		drain();

		// Clock path at the top clock: integer 65535 with a fraction that rounds up to
		// a full 64 and wraps, then one step over range; spare index write on the way
		apply_config(W_CAP | W_REF | W_SPARE, '0, '0, '0, 32'hA5A5_5A5A);
		pending_bauds = '{24'd4096, 24'd4095, 24'd1, 24'd0};
		drain();

		// Zero reference on the scaling path, then zero clock with zero baud
		apply_config(W_CAP | W_CLK, 32'd5, '0, '0, '0);
		pending_bauds = '{24'd1000, 24'd0};
		drain();

		// Fraction wrap with a small clock: remainder 127 of 128
		apply_config(W_CAP | W_CLK, '0, '0, 32'd12927, '0);
		pending_bauds = '{24'd8};
		drain();

		// Zero clock on the clock path with a nonzero baud
		apply_config(W_CLK, '0, '0, '0, '0);
		pending_bauds = '{24'd300};

		// Random part: three flow-control modes, several setups in each
		for (int mode = 0; mode < 3; mode++) begin
			drain();
			case (mode)
				0: begin
					send_idle_pct = 14;
					recv_idle_pct = 57;
				end
				1: begin
					send_idle_pct = 57;
					recv_idle_pct = 14;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int phase = 0; phase < PHASES_PER_MODE; phase++) begin
				drain();
				choose_config(mode == 0 && phase == 0);
				repeat (ITEMS_PER_PHASE) pending_bauds.push_back(pick_baud());
			end
		end

		drain();
		// room for a stray result beat to show up
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog: tens of times the slowest expected run
	initial begin : watchdog
		#40_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
